[src/srcd_pkg.sv]
// shared types, codes and helpers for the shift register chain driver
package srcd_pkg;

	localparam int MAX_CHIPS = 4;
	localparam int BYTE_W    = 8;
	localparam int BIT_W     = $clog2(BYTE_W);
	localparam int POS_W     = (MAX_CHIPS > 1) ? $clog2(MAX_CHIPS) : 1;
	localparam int SUM_W     = ($clog2(2 * MAX_CHIPS) > 3) ? $clog2(2 * MAX_CHIPS) : 3;
	localparam int CFG_W     = 16;
	localparam int CIDX_W    = 3;

	typedef logic [POS_W-1:0] pos_t;
	typedef logic [SUM_W-1:0] sum_t;

	typedef enum logic [2:0] {
		OP_SHIFT   = 3'd0,
		OP_WRITE   = 3'd1,
		OP_LATCH   = 3'd2,
		OP_OE_ON   = 3'd3,
		OP_OE_OFF  = 3'd4,
		OP_RESET   = 3'd5
	} op_t;

	typedef enum logic [2:0] {
		EV_SHIFT = 3'd0,
		EV_LATCH = 3'd1,
		EV_OE    = 3'd2,
		EV_MR    = 3'd3,
		EV_ERROR = 3'd4
	} ev_t;

	typedef enum logic [CIDX_W-1:0] {
		CFG_DEVICE_COUNT = 3'd0,
		CFG_HAS_OE       = 3'd1,
		CFG_HAS_MR       = 3'd2,
		CFG_HALF_PERIOD  = 3'd3,
		CFG_PULSE_WIDTH  = 3'd4
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_SHIFT,
		ST_LATCH,
		ST_EVENT
	} st_t;

	typedef struct packed {
		op_t              op;
		logic [7:0]       data_byte;
		logic [1:0]       device_index;
	} cmd_t;

	typedef struct packed {
		ev_t  event_kind;
		logic serial_bit;
		logic enable_pin_level;
		logic last;
	} evt_t;

	typedef struct packed {
		logic              load;
		logic              shift;
		logic [BYTE_W-1:0] data;
	} ser_ctl_t;

	typedef struct packed {
		logic sdata;
		logic last_bit;
	} ser_sts_t;

	typedef struct packed {
		logic              clr;
		logic              wr;
		pos_t              wr_pos;
		logic [BYTE_W-1:0] wr_data;
		logic              head_wr;
		pos_t              head_val;
		pos_t              rd_pos;
	} shd_ctl_t;

	// device_count 0 acts as one chip, anything above the maximum as the maximum
	function automatic sum_t active_count(logic [2:0] dev);
		sum_t r;
		r = SUM_W'(dev);
		if (dev == 3'd0) begin
			r = SUM_W'(1);
		end else if (SUM_W'(dev) > SUM_W'(MAX_CHIPS)) begin
			r = SUM_W'(MAX_CHIPS);
		end
		return r;
	endfunction

	// value known to be below twice n
	function automatic pos_t wrap_pos(sum_t v, sum_t n);
		sum_t r;
		r = (v >= n) ? (v - n) : v;
		return POS_W'(r);
	endfunction

	// stored head may exceed a chip count that was lowered since
	function automatic pos_t mod_pos(pos_t v, sum_t n);
		sum_t r;
		r = SUM_W'(v);
		for (int k = 0; k < MAX_CHIPS; k++) begin
			if (r >= n) begin
				r = r - n;
			end
		end
		return POS_W'(r);
	endfunction

endpackage

[src/srcd_ser.sv]
// one-bit serializer: byte shift register with bit counter, lsb first
module srcd_ser (
	input  logic               clk,
	input  logic               arst_n,
	input  srcd_pkg::ser_ctl_t ctl,
	output srcd_pkg::ser_sts_t sts
);
	import srcd_pkg::*;

	logic [BYTE_W-1:0] sr_q;
	logic [BIT_W-1:0]  cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.load) begin
			cnt_q <= '0;
		end else if (ctl.shift) begin
			cnt_q <= cnt_q + BIT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			sr_q <= ctl.data;
		end else if (ctl.shift) begin
			sr_q <= {1'b0, sr_q[BYTE_W-1:1]};
		end
	end

	assign sts.sdata    = sr_q[0];
	assign sts.last_bit = (cnt_q == BIT_W'(BYTE_W - 1));

endmodule

[src/srcd_shadow.sv]
// shadow copy of the bytes held in the chain, with ring head pointer
module srcd_shadow (
	input  logic                    clk,
	input  logic                    arst_n,
	input  srcd_pkg::shd_ctl_t      ctl,
	output logic [7:0]              rd_data,
	output srcd_pkg::pos_t          ring_head
);
	import srcd_pkg::*;

	logic [BYTE_W-1:0] bytes_q [MAX_CHIPS];
	pos_t              head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_CHIPS; i++) begin
				bytes_q[i] <= '0;
			end
		end else if (ctl.clr) begin
			for (int i = 0; i < MAX_CHIPS; i++) begin
				bytes_q[i] <= '0;
			end
		end else if (ctl.wr) begin
			bytes_q[ctl.wr_pos] <= ctl.wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
		end else if (ctl.head_wr) begin
			head_q <= ctl.head_val;
		end
	end

	assign rd_data   = bytes_q[ctl.rd_pos];
	assign ring_head = head_q;

endmodule

[src/shift_register_chain_driver_top.sv]
// top level: command decode, sequencing, configuration and event output register
//
// Drives a chain of up to four serial-in parallel-out shift register chips and reports
// every pin event as one output word. A byte goes out lsb first through a one-bit
// serializer: each byte is loaded once, then for every bit the sequencer counts down
// shift_half_period and emits the bit; a shift-byte command sends one byte and a
// write-to-index command one byte for each of the n active chips. A reset without the
// master reset pin shifts zeros into every chip and counts down latch_pulse_width
// before the latch word, and a latch command counts down latch_pulse_width before its
// word. One command is worked at a time; stalls on the output hold the sequence.
// Configuration is to be written only while idle: the user is bound, the block does not enforce it.
module shift_register_chain_driver_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cmd_valid,
	output logic                         cmd_ready,
	input  srcd_pkg::cmd_t               cmd,
	output logic                         evt_valid,
	input  logic                         evt_ready,
	output srcd_pkg::evt_t               evt,
	input  logic                         cfg_wr_en,
	input  logic [srcd_pkg::CIDX_W-1:0]  cfg_index,
	input  logic [srcd_pkg::CFG_W-1:0]   cfg_data
);
	import srcd_pkg::*;

	// configuration
	logic [2:0]       dev_count_q;
	logic             has_oe_q;
	logic             has_mr_q;
	logic [CFG_W-1:0] half_period_q;
	logic [CFG_W-1:0] pulse_width_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_count_q   <= 3'd1;
			has_oe_q      <= 1'b0;
			has_mr_q      <= 1'b0;
			half_period_q <= '0;
			pulse_width_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_DEVICE_COUNT: dev_count_q   <= cfg_data[2:0];
				CFG_HAS_OE:       has_oe_q      <= cfg_data[0];
				CFG_HAS_MR:       has_mr_q      <= cfg_data[0];
				CFG_HALF_PERIOD:  half_period_q <= cfg_data;
				CFG_PULSE_WIDTH:  pulse_width_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer state
	st_t              state_q, state_d;
	op_t              op_q, op_d;
	logic [7:0]       data_q, data_d;
	logic [1:0]       idx_q, idx_d;
	sum_t             n_q, n_d;
	pos_t             h_q, h_d;
	pos_t             j_q, j_d;
	ev_t              kind_q, kind_d;
	logic [CFG_W-1:0] gap_q, gap_d;
	logic             oe_q, oe_d;

	logic             out_valid_q;
	evt_t             out_q;
	logic             out_free;
	logic             emit;
	evt_t             ew;

	ser_ctl_t         ser_ctl;
	ser_sts_t         ser_sts;
	shd_ctl_t         shd_ctl;
	logic [7:0]       shd_rd;
	pos_t             ring_head;
	sum_t             n_act;
	pos_t             h_act;

	srcd_ser u_ser (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ser_ctl),
		.sts    (ser_sts)
	);

	srcd_shadow u_shadow (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (shd_ctl),
		.rd_data   (shd_rd),
		.ring_head (ring_head)
	);

	assign out_free = !out_valid_q || evt_ready;
	assign n_act    = active_count(dev_count_q);
	assign h_act    = mod_pos(ring_head, n_act);

	always_comb begin
		state_d   = state_q;
		op_d      = op_q;
		data_d    = data_q;
		idx_d     = idx_q;
		n_d       = n_q;
		h_d       = h_q;
		j_d       = j_q;
		kind_d    = kind_q;
		gap_d     = gap_q;
		oe_d      = oe_q;
		cmd_ready = (state_q == ST_IDLE);
		emit      = 1'b0;
		ew        = '0;
		ser_ctl   = '0;
		shd_ctl   = '0;
		shd_ctl.rd_pos = wrap_pos(SUM_W'(h_q) + SUM_W'(j_q), n_q);

		ew.enable_pin_level = !oe_q;

		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					op_d   = cmd.op;
					data_d = cmd.data_byte;
					idx_d  = cmd.device_index;
					n_d    = n_act;
					h_d    = h_act;
					unique case (cmd.op)
						OP_SHIFT: begin
							j_d     = '0;
							state_d = ST_LOAD;
						end
						OP_WRITE: begin
							if (SUM_W'(cmd.device_index) >= n_act) begin
								kind_d  = EV_ERROR;
								state_d = ST_EVENT;
							end else begin
								j_d     = POS_W'(n_act - SUM_W'(1));
								state_d = ST_LOAD;
							end
						end
						OP_LATCH: begin
							gap_d   = pulse_width_q;
							state_d = ST_LATCH;
						end
						OP_OE_ON, OP_OE_OFF: begin
							if (!has_oe_q) begin
								kind_d = EV_ERROR;
							end else begin
								oe_d   = (cmd.op == OP_OE_ON);
								kind_d = EV_OE;
							end
							state_d = ST_EVENT;
						end
						OP_RESET: begin
							shd_ctl.clr = 1'b1;
							if (has_mr_q) begin
								kind_d  = EV_MR;
								state_d = ST_EVENT;
							end else begin
								// zeros into every chip, then a latch pulse
								j_d     = POS_W'(n_act - SUM_W'(1));
								state_d = ST_LOAD;
							end
						end
						default: begin
							kind_d  = EV_ERROR;
							state_d = ST_EVENT;
						end
					endcase
				end
			end
			ST_LOAD: begin
				ser_ctl.load = 1'b1;
				priority if (op_q == OP_RESET) begin
					ser_ctl.data = '0;
				end else if (op_q == OP_WRITE && SUM_W'(j_q) != SUM_W'(idx_q)) begin
					// untouched chips get their shadow byte back
					ser_ctl.data = shd_rd;
				end else begin
					ser_ctl.data = data_q;
				end
				gap_d   = half_period_q;
				state_d = ST_SHIFT;
			end
			ST_SHIFT: begin
				if (gap_q != '0) begin
					gap_d = gap_q - CFG_W'(1);
				end else if (out_free) begin
					emit          = 1'b1;
					ew.event_kind = EV_SHIFT;
					ew.serial_bit = ser_sts.sdata;
					ew.last       = ser_sts.last_bit && (j_q == '0) && (op_q != OP_RESET);
					ser_ctl.shift = 1'b1;
					gap_d         = half_period_q;
					if (ser_sts.last_bit) begin
						if (j_q == '0) begin
							shd_ctl.head_wr = 1'b1;
							priority if (op_q == OP_SHIFT) begin
								shd_ctl.head_val = wrap_pos(SUM_W'(h_q) + n_q - SUM_W'(1), n_q);
								shd_ctl.wr       = 1'b1;
								shd_ctl.wr_pos   = shd_ctl.head_val;
								shd_ctl.wr_data  = data_q;
							end else if (op_q == OP_WRITE) begin
								shd_ctl.head_val = h_q;
								shd_ctl.wr       = 1'b1;
								shd_ctl.wr_pos   = wrap_pos(SUM_W'(h_q) + SUM_W'(idx_q), n_q);
								shd_ctl.wr_data  = data_q;
							end else begin
								shd_ctl.head_val = h_q;
							end
							if (op_q == OP_RESET) begin
								gap_d   = pulse_width_q;
								state_d = ST_LATCH;
							end else begin
								state_d = ST_IDLE;
							end
						end else begin
							j_d     = j_q - POS_W'(1);
							state_d = ST_LOAD;
						end
					end
				end
			end
			ST_LATCH: begin
				if (gap_q != '0) begin
					gap_d = gap_q - CFG_W'(1);
				end else if (out_free) begin
					emit          = 1'b1;
					ew.event_kind = EV_LATCH;
					ew.last       = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			ST_EVENT: begin
				if (out_free) begin
					emit          = 1'b1;
					ew.event_kind = kind_q;
					ew.last       = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			oe_q        <= 1'b0;
			gap_q       <= '0;
			j_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			oe_q    <= oe_d;
			gap_q   <= gap_d;
			j_q     <= j_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (evt_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		op_q   <= op_d;
		data_q <= data_d;
		idx_q  <= idx_d;
		n_q    <= n_d;
		h_q    <= h_d;
		kind_q <= kind_d;
		if (emit) begin
			out_q <= ew;
		end
	end

	assign evt_valid = out_valid_q;
	assign evt       = out_q;

`ifndef NO_ASSERTIONS
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && cmd_ready) |=> !cmd_ready)
		else $error("command accepted but sequencer stayed idle");

	a_data_only_on_shift: assert property (@(posedge clk) disable iff (!arst_n)
		(evt_valid && evt.event_kind != EV_SHIFT) |-> !evt.serial_bit)
		else $error("data line set on a non-shift word");

	a_single_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(evt_valid && (evt.event_kind == EV_OE || evt.event_kind == EV_MR ||
			evt.event_kind == EV_ERROR)) |-> evt.last)
		else $error("single-event word not marked last");
`endif

endmodule

[tb/shift_register_chain_driver_top_tb.sv]
// self-checking testbench for the shift register chain driver: commands in, predicted pin events out
module shift_register_chain_driver_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import srcd_pkg::*;

	localparam logic [2:0] OP_UNDEF_A    = 3'd6;
	localparam logic [2:0] OP_UNDEF_B    = 3'd7;
	localparam int         SETTLE_CYCLES = 8;
	localparam int         QUIET_LIMIT   = 300000;
	localparam int         PHASE_ITEMS   = 30;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              cmd_valid = 1'b0;
	logic              cmd_ready;
	cmd_t              cmd       = '0;
	logic              evt_valid;
	logic              evt_ready = 1'b0;
	evt_t              evt;
	logic              cfg_wr_en = 1'b0;
	logic [CIDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]  cfg_data  = '0;

	// copy of the configuration registers that change the events
	logic [2:0]  chain_len_cfg   = 3'd1;
	bit          oe_wired        = 1'b0;
	bit          mr_wired        = 1'b0;

	// copy of the chain state
	logic [7:0]  chain_shadow [MAX_CHIPS] = '{default: 8'h00};
	int unsigned ring_pos   = 0;
	bit          outputs_on = 1'b0;

	cmd_t cmd_pending [$];
	evt_t events_due [$];
	int   mismatches   = 0;
	int   quiet_cycles = 0;
	int   gap_left     = 0;
	int   stall_left   = 0;
	bit   idle_mode    = 1'b1;

	shift_register_chain_driver_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.evt_valid (evt_valid),
		.evt_ready (evt_ready),
		.evt       (evt),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#2ns clk = 1'b1;
		#2ns clk = 1'b0;
	end

	function automatic int unsigned chips_in_use();
		if (chain_len_cfg == 3'd0) begin
			return 1;
		end
		if (chain_len_cfg > MAX_CHIPS) begin
			return MAX_CHIPS;
		end
		return chain_len_cfg;
	endfunction

	function automatic int pick_gap();
		int unsigned roll;
		if (!idle_mode) begin
			return 0;
		end
		roll = $urandom_range(0, 99);
		if (roll < 60) begin
			return 0;
		end else if (roll < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	function automatic void expect_event(ev_t kind, logic bit_level);
		evt_t e;
		e.event_kind       = kind;
		e.serial_bit       = bit_level;
		e.enable_pin_level = ~outputs_on;
		e.last             = 1'b0;
		events_due.push_back(e);
	endfunction

	// lsb first, then the new byte becomes the ring head
	function automatic void expect_byte_shift(logic [7:0] b);
		int unsigned n;
		int unsigned h;
		n = chips_in_use();
		for (int i = 0; i < 8; i++) begin
			expect_event(EV_SHIFT, b[i]);
		end
		h = (ring_pos % n + n - 1) % n;
		ring_pos = h;
		chain_shadow[h] = b;
	endfunction

	function automatic void predict_pin_events(cmd_t c);
		int unsigned n;
		int unsigned h;
		logic [7:0]  rebuilt [MAX_CHIPS];
		evt_t        tail;
		n = chips_in_use();
		case (c.op)
			OP_SHIFT: begin
				expect_byte_shift(c.data_byte);
			end
			OP_WRITE: begin
				if (c.device_index >= n) begin
					expect_event(EV_ERROR, 1'b0);
				end else begin
					// unroll the ring so position 0 is the newest byte, replay oldest first
					h = ring_pos % n;
					for (int i = 0; i < n; i++) begin
						rebuilt[i] = chain_shadow[(h + i) % n];
					end
					rebuilt[c.device_index] = c.data_byte;
					for (int i = n; i > 0; i--) begin
						expect_byte_shift(rebuilt[i - 1]);
					end
				end
			end
			OP_LATCH: begin
				expect_event(EV_LATCH, 1'b0);
			end
			OP_OE_ON, OP_OE_OFF: begin
				if (!oe_wired) begin
					expect_event(EV_ERROR, 1'b0);
				end else begin
					outputs_on = (c.op == OP_OE_ON);
					expect_event(EV_OE, 1'b0);
				end
			end
			OP_RESET: begin
				if (mr_wired) begin
					expect_event(EV_MR, 1'b0);
				end else begin
					// no reset pin: flush zeros through every chip and latch them
					for (int i = 0; i < n; i++) begin
						expect_byte_shift(8'h00);
					end
					expect_event(EV_LATCH, 1'b0);
				end
				foreach (chain_shadow[i]) begin
					chain_shadow[i] = 8'h00;
				end
			end
			default: begin
				expect_event(EV_ERROR, 1'b0);
			end
		endcase
		tail = events_due[events_due.size() - 1];
		tail.last = 1'b1;
		events_due[events_due.size() - 1] = tail;
	endfunction

	function automatic void queue_cmd(logic [2:0] code, logic [7:0] d, logic [1:0] idx);
		cmd_t c;
		c.op           = op_t'(code);
		c.data_byte    = d;
		c.device_index = idx;
		cmd_pending.push_back(c);
	endfunction

	function automatic cmd_t random_cmd();
		cmd_t        c;
		int unsigned roll;
		roll = $urandom_range(0, 99);
		c.data_byte    = 8'($urandom_range(0, 255));
		c.device_index = 2'($urandom_range(0, 3));
		if (roll < 32) begin
			c.op = OP_SHIFT;
		end else if (roll < 57) begin
			c.op = OP_WRITE;
			// most writes land inside the active chain
			if ($urandom_range(0, 4) != 0) begin
				c.device_index = 2'($urandom_range(0, chips_in_use() - 1));
			end
		end else if (roll < 67) begin
			c.op = OP_LATCH;
		end else if (roll < 74) begin
			c.op = OP_OE_ON;
		end else if (roll < 81) begin
			c.op = OP_OE_OFF;
		end else if (roll < 90) begin
			c.op = OP_RESET;
		end else begin
			c.op = op_t'((roll < 95) ? OP_UNDEF_A : OP_UNDEF_B);
		end
		return c;
	endfunction

	task automatic queue_random(int count);
		int k;
		k = 0;
		while (k < count) begin
			if ($urandom_range(0, 9) < 3) begin
				// fill the whole chain, then latch it
				for (int i = 0; i < chips_in_use(); i++) begin
					queue_cmd(OP_SHIFT, 8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)));
				end
				queue_cmd(OP_LATCH, 8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)));
				k += chips_in_use() + 1;
			end else begin
				cmd_pending.push_back(random_cmd());
				k++;
			end
		end
	endtask

	// checked away from the rising edge so the driver's updates have settled
	task automatic wait_idle();
		@(negedge clk);
		while (cmd_pending.size() != 0 || cmd_valid || events_due.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			CFG_DEVICE_COUNT: chain_len_cfg   = val[2:0];
			CFG_HAS_OE:       oe_wired        = val[0];
			CFG_HAS_MR:       mr_wired        = val[0];
			default: ;
		endcase
	endtask

	task automatic configure(logic [2:0] dev, bit oe, bit mr, logic [15:0] hp, logic [15:0] pw);
		wait_idle();
		write_reg(CFG_DEVICE_COUNT, CFG_W'(dev));
		write_reg(CFG_HAS_OE, CFG_W'(oe));
		write_reg(CFG_HAS_MR, CFG_W'(mr));
		write_reg(CFG_HALF_PERIOD, hp);
		write_reg(CFG_PULSE_WIDTH, pw);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		idle_mode = ($urandom_range(0, 3) != 0);
	endtask

	// command driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid <= 1'b0;
			cmd       <= '0;
		end else begin
			if (cmd_valid && cmd_ready) begin
				predict_pin_events(cmd);
				gap_left = pick_gap();
			end
			if (!cmd_valid || cmd_ready) begin
				if (gap_left == 0 && cmd_pending.size() != 0) begin
					cmd       <= cmd_pending.pop_front();
					cmd_valid <= 1'b1;
				end else begin
					if (gap_left != 0) begin
						gap_left--;
					end
					cmd_valid <= 1'b0;
				end
			end
		end
	end

	// event monitor
	always @(posedge clk or negedge arst_n) begin
		evt_t want;
		bit   take;
		if (!arst_n) begin
			evt_ready <= 1'b0;
		end else begin
			if (evt_valid && evt_ready) begin
				if (events_due.size() == 0) begin
					$display("%0t: unexpected pin event: expected none,", $time);
					$display("%0t:   got kind=%0d bit=%b oe_n=%b last=%b", $time,
						evt.event_kind, evt.serial_bit, evt.enable_pin_level, evt.last);
					mismatches++;
				end else begin
					want = events_due.pop_front();
					if (evt.event_kind !== want.event_kind || evt.serial_bit !== want.serial_bit ||
						evt.enable_pin_level !== want.enable_pin_level || evt.last !== want.last) begin
						$display("%0t: pin event mismatch: expected kind=%0d bit=%b oe_n=%b last=%b,",
							$time, want.event_kind, want.serial_bit, want.enable_pin_level, want.last);
						$display("%0t:   got kind=%0d bit=%b oe_n=%b last=%b", $time,
							evt.event_kind, evt.serial_bit, evt.enable_pin_level, evt.last);
						mismatches++;
					end
				end
			end
			if (stall_left != 0) begin
				stall_left--;
				take = 1'b0;
			end else begin
				take = 1'b1;
				stall_left = pick_gap();
			end
			evt_ready <= take;
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_valid && cmd_ready) || (evt_valid && evt_ready) || cfg_wr_en) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	initial begin
		logic [2:0]  dev_list [8] = '{3'd2, 3'd3, 3'd0, 3'd7, 3'd5, 3'd4, 3'd1, 3'd4};
		bit          oe_list  [8] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0};
		bit          mr_list  [8] = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
		logic [15:0] hp_list  [8] = '{16'd1, 16'd0, 16'd2, 16'd0, 16'd3, 16'd0, 16'd1, 16'd2};
		logic [15:0] pw_list  [8] = '{16'd2, 16'd1, 16'd0, 16'd3, 16'd0, 16'd0, 16'd1, 16'd2};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: one chip, no enable pin, no master reset pin
		queue_cmd(OP_SHIFT, 8'h00, 2'd0);
		queue_cmd(OP_SHIFT, 8'hFF, 2'd3);
		queue_cmd(OP_SHIFT, 8'hA5, 2'd0);
		queue_cmd(OP_LATCH, 8'h00, 2'd0);
		queue_cmd(OP_WRITE, 8'h3C, 2'd0);
		queue_cmd(OP_WRITE, 8'h77, 2'd1);
		queue_cmd(OP_OE_ON, 8'h00, 2'd0);
		queue_cmd(OP_OE_OFF, 8'h00, 2'd0);
		queue_cmd(OP_RESET, 8'h00, 2'd0);
		queue_cmd(OP_UNDEF_A, 8'hFF, 2'd3);
		queue_cmd(OP_UNDEF_B, 8'h00, 2'd0);

		// full chain with both pins wired
		configure(3'd4, 1'b1, 1'b1, 16'd0, 16'd0);
		queue_cmd(OP_SHIFT, 8'h01, 2'd0);
		queue_cmd(OP_SHIFT, 8'h80, 2'd0);
		queue_cmd(OP_SHIFT, 8'h55, 2'd0);
		queue_cmd(OP_WRITE, 8'hFF, 2'd3);
		queue_cmd(OP_WRITE, 8'h00, 2'd0);
		queue_cmd(OP_OE_ON, 8'h00, 2'd0);
		queue_cmd(OP_LATCH, 8'h00, 2'd0);
		queue_cmd(OP_OE_OFF, 8'h00, 2'd0);
		queue_cmd(OP_RESET, 8'h00, 2'd0);
		queue_cmd(OP_WRITE, 8'hC3, 2'd2);

		foreach (dev_list[p]) begin
			configure(dev_list[p], oe_list[p], mr_list[p], hp_list[p], pw_list[p]);
			queue_random(PHASE_ITEMS);
		end

		// widest timing; only commands that do not shift, so the run stays short
		configure(3'd1, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF);
		queue_cmd(OP_LATCH, 8'h00, 2'd0);
		queue_cmd(OP_OE_ON, 8'h00, 2'd0);
		queue_cmd(OP_WRITE, 8'h5A, 2'd2);
		queue_cmd(OP_UNDEF_B, 8'hFF, 2'd1);
		queue_cmd(OP_RESET, 8'h00, 2'd0);
		queue_cmd(OP_OE_OFF, 8'h00, 2'd0);

		wait_idle();
		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

[files.f]
src/srcd_pkg.sv
src/srcd_ser.sv
src/srcd_shadow.sv
src/shift_register_chain_driver_top.sv
tb/shift_register_chain_driver_top_tb.sv
